[design/fmfc_pkg.sv]
`default_nettype none
package fmfc_pkg;

    localparam int NUM_LANDMARKS = 68;
    localparam int NUM_COEFS     = 50;
    localparam int NUM_ROWS      = 204;
    localparam int NUM_REGS      = 8;

    localparam int BASIS_DEPTH  = NUM_ROWS * NUM_COEFS;
    localparam int TARGET_DEPTH = 2 * NUM_LANDMARKS;

    localparam int BA_W  = $clog2(BASIS_DEPTH);
    localparam int TA_W  = $clog2(TARGET_DEPTH);
    localparam int VA_W  = $clog2(NUM_ROWS);
    localparam int CA_W  = $clog2(NUM_COEFS);
    localparam int LM_W  = $clog2(NUM_LANDMARKS);
    localparam int RI_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W = 4;

    localparam int SLOT_W   = 14;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 56;
    localparam int AMOUNT_W = 48;
    localparam int COMP_W   = 6;

    localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
    localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;

    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [2:0] {
        KIND_BASIS    = 3'd0,
        KIND_TARGET   = 3'd1,
        KIND_PRIOR    = 3'd2,
        KIND_COEF     = 3'd3,
        KIND_EVAL     = 3'd4,
        KIND_GRADIENT = 3'd5
    } kind_t;

    typedef enum logic [6:0] {
        P_IDLE  = 7'b0000001,
        P_VERT  = 7'b0000010,
        P_RESID = 7'b0000100,
        P_RSQ   = 7'b0001000,
        P_PRIOR = 7'b0010000,
        P_GRAD  = 7'b0100000,
        P_EMIT  = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        ST_ADDR = 3'b001,
        ST_MUL  = 3'b010,
        ST_ACC  = 3'b100
    } step_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
            return a[63] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

    function automatic logic signed [48:0] round16(input logic signed [63:0] a);
        logic signed [48:0] r;
        r = 49'(a >>> 16) + $signed({48'd0, a[15]});
        return r;
    endfunction

    function automatic logic signed [31:0] to_q16(input logic signed [63:0] a);
        logic signed [48:0] r;
        r = round16(a);
        if (r > 49'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (r < -49'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(r);
    endfunction

    function automatic logic signed [47:0] to_amount(input logic signed [63:0] a);
        logic signed [48:0] r;
        r = round16(a);
        if (r > 49'sd140737488355327) begin
            return {1'b0, {47{1'b1}}};
        end else if (r < -49'sd140737488355328) begin
            return {1'b1, {47{1'b0}}};
        end
        return 48'(r);
    endfunction

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32] != d[31]) begin
            return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return 32'(d);
    endfunction

endpackage
`default_nettype wire

[design/fmfc_mac.sv]
`default_nettype none
module fmfc_mac (
    input  wire logic               aclk,
    input  wire logic signed [31:0] op_a,
    input  wire logic signed [31:0] op_b,
    output logic signed [63:0]      prod
);

    logic signed [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

[design/face_model_fitting_cost.sv]
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata {value_two, value, slot}, s_tuser kind
// m_        out  m_tvalid/m_tready  m_tdata {component, amount}, m_tlast last
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
// a load is written into its store when accepted; every multiply on the shared
// multiplier steps through memory read, product register and accumulate
// aresetn is synchronous and clears control state; stores hold garbage until loaded
// s_tready is low while a request is being evaluated; a gradient run stalls on m_tready
`default_nettype none
module face_model_fitting_cost (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [fmfc_pkg::IN_W-1:0]     s_tdata,   // slot, value, value_two
    input  wire logic [2:0]                    s_tuser,   // kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [fmfc_pkg::OUT_W-1:0]         m_tdata,   // amount, component
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fmfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam int BA_W = fmfc_pkg::BA_W;
    localparam int TA_W = fmfc_pkg::TA_W;
    localparam int VA_W = fmfc_pkg::VA_W;
    localparam int CA_W = fmfc_pkg::CA_W;
    localparam int LM_W = fmfc_pkg::LM_W;

    // storage
    logic signed [31:0] basis_mem  [fmfc_pkg::BASIS_DEPTH];
    logic signed [31:0] target_mem [fmfc_pkg::TARGET_DEPTH];
    logic signed [31:0] resid_mem  [fmfc_pkg::TARGET_DEPTH];
    logic signed [31:0] vert_mem   [fmfc_pkg::NUM_ROWS];
    logic signed [31:0] mean_mem   [fmfc_pkg::NUM_COEFS];
    logic signed [31:0] weight_mem [fmfc_pkg::NUM_COEFS];
    logic signed [31:0] coef_mem   [fmfc_pkg::NUM_COEFS];

    logic signed [31:0] basis_rd, target_rd, resid_rd, vert_rd, mean_rd, weight_rd, coef_rd;

    logic signed [31:0] cfg_regs_reg [fmfc_pkg::NUM_REGS];

    fmfc_pkg::phase_t phase_reg, phase_next;
    fmfc_pkg::step_t  step_reg, step_next;
    logic             grad_reg, grad_next;
    logic [VA_W-1:0]  row_reg, row_next;
    logic [CA_W-1:0]  col_reg, col_next;
    logic [2:0]       term_reg, term_next;
    logic             axis_reg, axis_next;
    logic [TA_W-1:0]  idx_reg, idx_next;
    logic [BA_W-1:0]  baddr_reg, baddr_next;
    logic [BA_W-1:0]  base_reg, base_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] jacc_reg, jacc_next;
    logic signed [31:0] j_reg, j_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [31:0] p_reg, p_next;
    logic             m_valid_reg, m_valid_next;
    logic signed [47:0] m_amount_reg, m_amount_next;
    logic [CA_W-1:0]  m_comp_reg, m_comp_next;
    logic             m_last_reg, m_last_next;

    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod;
    logic signed [63:0] nacc;

    logic             in_fire;
    fmfc_pkg::kind_t  in_kind;
    logic [13:0]      in_slot;
    logic signed [31:0] in_value, in_value_two;

    logic             vert_we, resid_we;
    logic signed [31:0] wr_q16;

    logic [BA_W-1:0]  basis_raddr;
    logic [VA_W-1:0]  vert_raddr;
    logic [TA_W-1:0]  pair_addr;
    logic [TA_W-1:0]  resid_raddr;
    logic [fmfc_pkg::RI_W-1:0] reg_sel;
    logic signed [31:0] d_val;

    assign in_kind      = fmfc_pkg::kind_t'(s_tuser);
    assign in_slot      = s_tdata[13:0];
    assign in_value     = s_tdata[45:14];
    assign in_value_two = s_tdata[77:46];

    assign s_tready  = (phase_reg == fmfc_pkg::P_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fmfc_pkg::NUM_REGS; i++) begin
                cfg_regs_reg[i] <= '0;
            end
        end else if (cfg_valid && (32'(cfg_index) < 32'(fmfc_pkg::NUM_REGS))) begin
            cfg_regs_reg[cfg_index[fmfc_pkg::RI_W-1:0]] <= cfg_data;
        end
    end

    // read addresses
    assign pair_addr   = TA_W'({row_reg[LM_W-1:0], axis_reg});
    assign vert_raddr  = VA_W'({row_reg, 1'b0}) + row_reg + VA_W'(term_reg);
    assign resid_raddr = (phase_reg == fmfc_pkg::P_RSQ) ? idx_reg : pair_addr;

    always_comb begin
        case (phase_reg)
            fmfc_pkg::P_GRAD: begin
                basis_raddr = base_reg + BA_W'(term_reg[1:0] * fmfc_pkg::NUM_COEFS);
            end
            default: begin
                basis_raddr = baddr_reg;
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (in_fire && (in_kind == fmfc_pkg::KIND_BASIS)
            && (32'(in_slot) < 32'(fmfc_pkg::BASIS_DEPTH))) begin
            basis_mem[in_slot[BA_W-1:0]] <= in_value;
        end
        basis_rd <= basis_mem[basis_raddr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (in_kind == fmfc_pkg::KIND_TARGET)
            && (32'(in_slot) < 32'(fmfc_pkg::TARGET_DEPTH))) begin
            target_mem[in_slot[TA_W-1:0]] <= in_value;
        end
        target_rd <= target_mem[pair_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (in_kind == fmfc_pkg::KIND_PRIOR)
            && (32'(in_slot) < 32'(fmfc_pkg::NUM_COEFS))) begin
            mean_mem[in_slot[CA_W-1:0]]   <= in_value;
            weight_mem[in_slot[CA_W-1:0]] <= in_value_two;
        end
        mean_rd   <= mean_mem[col_reg];
        weight_rd <= weight_mem[col_reg];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && (in_kind == fmfc_pkg::KIND_COEF)
            && (32'(in_slot) < 32'(fmfc_pkg::NUM_COEFS))) begin
            coef_mem[in_slot[CA_W-1:0]] <= in_value;
        end
        coef_rd <= coef_mem[col_reg];
    end

    always_ff @(posedge aclk) begin
        if (vert_we) begin
            vert_mem[row_reg] <= wr_q16;
        end
        vert_rd <= vert_mem[vert_raddr];
    end

    always_ff @(posedge aclk) begin
        if (resid_we) begin
            resid_mem[pair_addr] <= wr_q16;
        end
        resid_rd <= resid_mem[resid_raddr];
    end

    // operand selection
    assign d_val = fmfc_pkg::sat_diff(coef_rd, mean_rd);

    always_comb begin
        if (term_reg < 3'd3) begin
            reg_sel = fmfc_pkg::RI_W'(term_reg) + (axis_reg ? fmfc_pkg::RI_W'(3) : '0);
        end else begin
            reg_sel = axis_reg ? fmfc_pkg::RI_W'(7) : fmfc_pkg::RI_W'(6);
        end
    end

    always_comb begin
        op_a = basis_rd;
        op_b = coef_rd;
        case (phase_reg)
            fmfc_pkg::P_RESID: begin
                if (term_reg == 3'd4) begin
                    op_a = target_rd;
                    op_b = fmfc_pkg::NEG_ONE_Q16;
                end else if (term_reg == 3'd3) begin
                    op_a = cfg_regs_reg[reg_sel];
                    op_b = fmfc_pkg::ONE_Q16;
                end else begin
                    op_a = cfg_regs_reg[reg_sel];
                    op_b = vert_rd;
                end
            end
            fmfc_pkg::P_RSQ: begin
                op_a = resid_rd;
                op_b = resid_rd;
            end
            fmfc_pkg::P_PRIOR: begin
                if (term_reg == 3'd0) begin
                    op_a = d_val;
                    op_b = weight_rd;
                end else begin
                    op_a = p_reg;
                    op_b = grad_reg ? fmfc_pkg::ONE_Q16 : d_reg;
                end
            end
            fmfc_pkg::P_GRAD: begin
                if (term_reg == 3'd3) begin
                    op_a = resid_rd;
                    op_b = j_reg;
                end else begin
                    op_a = cfg_regs_reg[reg_sel];
                    op_b = basis_rd;
                end
            end
            default: begin
                op_a = basis_rd;
                op_b = coef_rd;
            end
        endcase
    end

    fmfc_mac u_mac (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // sequencer
    always_comb begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        grad_next     = grad_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        term_next     = term_reg;
        axis_next     = axis_reg;
        idx_next      = idx_reg;
        baddr_next    = baddr_reg;
        base_next     = base_reg;
        acc_next      = acc_reg;
        jacc_next     = jacc_reg;
        j_next        = j_reg;
        d_next        = d_reg;
        p_next        = p_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_amount_next = m_amount_reg;
        m_comp_next   = m_comp_reg;
        m_last_next   = m_last_reg;
        vert_we       = 1'b0;
        resid_we      = 1'b0;
        nacc          = fmfc_pkg::sat_add(acc_reg, prod);
        wr_q16        = fmfc_pkg::to_q16(nacc);

        case (phase_reg)
            fmfc_pkg::P_IDLE: begin
                if (in_fire && ((in_kind == fmfc_pkg::KIND_EVAL)
                                || (in_kind == fmfc_pkg::KIND_GRADIENT))) begin
                    phase_next = fmfc_pkg::P_VERT;
                    step_next  = fmfc_pkg::ST_ADDR;
                    grad_next  = (in_kind == fmfc_pkg::KIND_GRADIENT);
                    row_next   = '0;
                    col_next   = '0;
                    term_next  = '0;
                    axis_next  = 1'b0;
                    baddr_next = '0;
                end
            end
            fmfc_pkg::P_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_amount_next = fmfc_pkg::to_amount(acc_reg);
                    m_comp_next   = grad_reg ? col_reg : '0;
                    m_last_next   = !grad_reg
                                    || (32'(col_reg) == fmfc_pkg::NUM_COEFS - 1);
                    if (grad_reg && (32'(col_reg) != fmfc_pkg::NUM_COEFS - 1)) begin
                        phase_next = fmfc_pkg::P_GRAD;
                        step_next  = fmfc_pkg::ST_ADDR;
                        col_next   = col_reg + 1'b1;
                        base_next  = BA_W'(col_reg) + 1'b1;
                        row_next   = '0;
                        term_next  = '0;
                        axis_next  = 1'b0;
                        acc_next   = '0;
                    end else begin
                        phase_next = fmfc_pkg::P_IDLE;
                    end
                end
            end
            default: begin
                case (step_reg)
                    fmfc_pkg::ST_ADDR: step_next = fmfc_pkg::ST_MUL;
                    fmfc_pkg::ST_MUL: begin
                        step_next = fmfc_pkg::ST_ACC;
                        if ((phase_reg == fmfc_pkg::P_PRIOR) && (term_reg == 3'd0)) begin
                            d_next = d_val;
                        end
                    end
                    default: begin
                        step_next = fmfc_pkg::ST_ADDR;
                        case (phase_reg)
                            fmfc_pkg::P_VERT: begin
                                if (col_reg == '0) begin
                                    nacc = prod;
                                end
                                wr_q16     = fmfc_pkg::to_q16(nacc);
                                acc_next   = nacc;
                                baddr_next = baddr_reg + 1'b1;
                                if (32'(col_reg) == fmfc_pkg::NUM_COEFS - 1) begin
                                    vert_we  = 1'b1;
                                    col_next = '0;
                                    if (32'(row_reg) == fmfc_pkg::NUM_ROWS - 1) begin
                                        phase_next = fmfc_pkg::P_RESID;
                                        row_next   = '0;
                                        term_next  = '0;
                                        axis_next  = 1'b0;
                                    end else begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end else begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                            fmfc_pkg::P_RESID: begin
                                if (term_reg == 3'd0) begin
                                    nacc = prod;
                                end
                                wr_q16   = fmfc_pkg::to_q16(nacc);
                                acc_next = nacc;
                                if (term_reg == 3'd4) begin
                                    resid_we  = 1'b1;
                                    term_next = '0;
                                    if (axis_reg) begin
                                        axis_next = 1'b0;
                                        if (32'(row_reg) == fmfc_pkg::NUM_LANDMARKS - 1) begin
                                            row_next = '0;
                                            col_next = '0;
                                            if (grad_reg) begin
                                                phase_next = fmfc_pkg::P_GRAD;
                                                base_next  = '0;
                                                acc_next   = '0;
                                            end else begin
                                                phase_next = fmfc_pkg::P_RSQ;
                                                idx_next   = '0;
                                            end
                                        end else begin
                                            row_next = row_reg + 1'b1;
                                        end
                                    end else begin
                                        axis_next = 1'b1;
                                    end
                                end else begin
                                    term_next = term_reg + 1'b1;
                                end
                            end
                            fmfc_pkg::P_RSQ: begin
                                if (idx_reg == '0) begin
                                    nacc = prod;
                                end
                                acc_next = nacc;
                                idx_next = idx_reg + 1'b1;
                                if (32'(idx_reg) == fmfc_pkg::TARGET_DEPTH - 1) begin
                                    phase_next = fmfc_pkg::P_PRIOR;
                                    col_next   = '0;
                                    term_next  = '0;
                                end
                            end
                            fmfc_pkg::P_PRIOR: begin
                                if (term_reg == 3'd0) begin
                                    p_next    = fmfc_pkg::to_q16(prod);
                                    term_next = 3'd1;
                                end else begin
                                    term_next = '0;
                                    if (grad_reg) begin
                                        acc_next   = fmfc_pkg::sat_add(nacc, nacc);
                                        phase_next = fmfc_pkg::P_EMIT;
                                    end else begin
                                        acc_next = nacc;
                                        if (32'(col_reg) == fmfc_pkg::NUM_COEFS - 1) begin
                                            phase_next = fmfc_pkg::P_EMIT;
                                        end else begin
                                            col_next = col_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                            fmfc_pkg::P_GRAD: begin
                                if (term_reg == 3'd3) begin
                                    acc_next  = nacc;
                                    term_next = '0;
                                    if (axis_reg) begin
                                        axis_next = 1'b0;
                                        base_next = base_reg
                                                    + BA_W'(3 * fmfc_pkg::NUM_COEFS);
                                        if (32'(row_reg) == fmfc_pkg::NUM_LANDMARKS - 1) begin
                                            phase_next = fmfc_pkg::P_PRIOR;
                                            row_next   = '0;
                                        end else begin
                                            row_next = row_reg + 1'b1;
                                        end
                                    end else begin
                                        axis_next = 1'b1;
                                    end
                                end else begin
                                    if (term_reg == 3'd0) begin
                                        jacc_next = prod;
                                    end else begin
                                        jacc_next = fmfc_pkg::sat_add(jacc_reg, prod);
                                    end
                                    if (term_reg == 3'd2) begin
                                        j_next = fmfc_pkg::to_q16(
                                            fmfc_pkg::sat_add(jacc_reg, prod));
                                    end
                                    term_next = term_reg + 1'b1;
                                end
                            end
                            default: begin
                                phase_next = fmfc_pkg::P_IDLE;
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= fmfc_pkg::P_IDLE;
            step_reg    <= fmfc_pkg::ST_ADDR;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        grad_reg     <= grad_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        term_reg     <= term_next;
        axis_reg     <= axis_next;
        idx_reg      <= idx_next;
        baddr_reg    <= baddr_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        jacc_reg     <= jacc_next;
        j_reg        <= j_next;
        d_reg        <= d_next;
        p_reg        <= p_next;
        m_amount_reg <= m_amount_next;
        m_comp_reg   <= m_comp_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, fmfc_pkg::COMP_W'(m_comp_reg), m_amount_reg};

endmodule
`default_nettype wire
